### rtl/core/ab2lp_pkg.sv
// Shared types and constants for the Annex B to length-prefixed NAL planner.
package ab2lp_pkg;

  localparam int unsigned OFFSET_BITS_DEF = 24;
  localparam int unsigned FIELD_W         = 24;
  localparam int unsigned NUM_SLOTS       = 3;
  localparam int unsigned CNT_W           = 2;

  localparam logic [4:0] NAL_TYPE_MASK = 5'h1f;
  localparam logic [4:0] NAL_TYPE_SPS  = 5'd7;
  localparam logic [4:0] NAL_TYPE_PPS  = 5'd8;
  localparam logic [31:0] START_CODE   = 32'h0000_0001;

  typedef enum logic [1:0] {
    KIND_LENGTH = 2'd0,
    KIND_TRIM   = 2'd1,
    KIND_END    = 2'd2
  } event_kind_e;

  typedef struct packed {
    event_kind_e        kind;
    logic [FIELD_W-1:0] offset;
    logic [FIELD_W-1:0] length;
    logic               last;
  } result_t;

  typedef result_t [NUM_SLOTS-1:0] result_set_t;

endpackage

### rtl/core/annexb_to_length_prefixed_nal_top.sv
// Top level of the Annex B to length-prefixed NAL rewrite planner.
// The first command of a byte is offered in the cycle after its transaction.
// Throughput: one byte per cycle while no byte leaves more than one command pending and
// the output is ready; a byte with more commands stalls the input (result slot drain).
// Reset clears the scan state and empties the result slots; the last byte of a
// buffer returns the scan state to its reset values.
module annexb_to_length_prefixed_nal_top #(
  parameter int unsigned OFFSET_BITS = ab2lp_pkg::OFFSET_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [23:0] byte_offset, [47:24] length_value
  output logic [1:0]  m_axis_tuser,   // [1:0] event_kind
  output logic        m_axis_tlast
);

  logic                        accept;
  ab2lp_pkg::result_set_t      results;
  logic [ab2lp_pkg::CNT_W-1:0] count;
  ab2lp_pkg::result_t          head;

  assign accept = s_axis_tvalid && s_axis_tready;

  ab2lp_scan #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (s_axis_tdata),
    .last_byte_i (s_axis_tlast),
    .results_o   (results),
    .count_o     (count)
  );

  ab2lp_outq u_outq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (accept),
    .results_i (results),
    .count_i   (count),
    .room_o    (s_axis_tready),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready),
    .head_o    (head)
  );

  assign m_axis_tdata = {head.length, head.offset};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

`ifndef SYNTHESIS
  a_end_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && s_axis_tlast |=> m_axis_tvalid)
    else $error("no command pending after last byte");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ab2lp_pkg::KIND_END) |-> m_axis_tlast)
    else $error("end command not marked last");

  a_trim_no_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != ab2lp_pkg::KIND_LENGTH) |-> (m_axis_tdata[47:24] == '0))
    else $error("nonzero length on trim or end command");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with no pending command");
`endif

endmodule

### rtl/core/ab2lp_scan.sv
// Start code detection, NAL bookkeeping and rewrite command generation.
module ab2lp_scan #(
  parameter int unsigned OFFSET_BITS = ab2lp_pkg::OFFSET_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [7:0]                   data_byte_i,
  input  logic                         last_byte_i,
  output ab2lp_pkg::result_set_t       results_o,
  output logic [ab2lp_pkg::CNT_W-1:0]  count_o
);

  localparam int unsigned EW = (OFFSET_BITS > ab2lp_pkg::FIELD_W) ?
                               OFFSET_BITS : ab2lp_pkg::FIELD_W;
  localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};
  localparam logic [OFFSET_BITS-1:0] FOUR    = OFFSET_BITS'(4);

  logic [31:0]            win_q, win_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [OFFSET_BITS-1:0] mark_q, mark_d;
  logic [5:0]             kind_q, kind_d;

  logic                   hit, seen, is_ps, v0, v1;
  logic [OFFSET_BITS-1:0] sc, pos_n, mark_n, len0, len1;
  logic [5:0]             kind_n;
  logic [EW-1:0]          sc_x, slot0_x, len0_x, slot1_x, len1_x, size_x;
  ab2lp_pkg::result_t     ev0, ev1, ev_end;
  logic [ab2lp_pkg::CNT_W-1:0] n;

  always_comb begin
    hit    = (pos_q >= FOUR) && (win_q == ab2lp_pkg::START_CODE);
    seen   = kind_q[5];
    is_ps  = (kind_q[4:0] == ab2lp_pkg::NAL_TYPE_SPS) ||
             (kind_q[4:0] == ab2lp_pkg::NAL_TYPE_PPS);
    sc     = pos_q - FOUR;
    len0   = (sc > mark_q) ? (sc - mark_q) : '0;
    mark_n = hit ? pos_q : mark_q;
    kind_n = hit ? {1'b1, data_byte_i[4:0] & ab2lp_pkg::NAL_TYPE_MASK} : kind_q;
    pos_n  = (pos_q == POS_MAX) ? pos_q : pos_q + 1'b1;
    len1   = (pos_n > mark_n) ? (pos_n - mark_n) : '0;

    sc_x    = EW'(sc);
    slot0_x = EW'(mark_q - FOUR);
    len0_x  = EW'(len0);
    slot1_x = EW'(mark_n - FOUR);
    len1_x  = EW'(len1);
    size_x  = EW'(pos_n);

    v0 = hit && seen;
    v1 = last_byte_i && kind_n[5];

    ev0.kind   = is_ps ? ab2lp_pkg::KIND_TRIM : ab2lp_pkg::KIND_LENGTH;
    ev0.offset = is_ps ? sc_x[ab2lp_pkg::FIELD_W-1:0] : slot0_x[ab2lp_pkg::FIELD_W-1:0];
    ev0.length = is_ps ? '0 : len0_x[ab2lp_pkg::FIELD_W-1:0];
    ev0.last   = 1'b0;

    ev1.kind   = ab2lp_pkg::KIND_LENGTH;
    ev1.offset = slot1_x[ab2lp_pkg::FIELD_W-1:0];
    ev1.length = len1_x[ab2lp_pkg::FIELD_W-1:0];
    ev1.last   = 1'b0;

    ev_end.kind   = ab2lp_pkg::KIND_END;
    ev_end.offset = size_x[ab2lp_pkg::FIELD_W-1:0];
    ev_end.length = '0;
    ev_end.last   = 1'b0;

    n = ab2lp_pkg::CNT_W'(v0) + ab2lp_pkg::CNT_W'(v1) + ab2lp_pkg::CNT_W'(last_byte_i);

    results_o[0] = v0 ? ev0 : (v1 ? ev1 : ev_end);
    results_o[1] = (v0 && v1) ? ev1 : ev_end;
    results_o[2] = ev_end;
    for (int i = 0; i < ab2lp_pkg::NUM_SLOTS; i++) begin
      results_o[i].last = (n == ab2lp_pkg::CNT_W'(i + 1));
    end
    count_o = n;

    if (last_byte_i) begin
      win_d  = '0;
      pos_d  = '0;
      mark_d = '0;
      kind_d = '0;
    end else begin
      win_d  = {win_q[23:0], data_byte_i};
      pos_d  = pos_n;
      mark_d = mark_n;
      kind_d = kind_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      pos_q  <= '0;
      mark_q <= '0;
      kind_q <= '0;
    end else if (accept_i) begin
      win_q  <= win_d;
      pos_q  <= pos_d;
      mark_q <= mark_d;
      kind_q <= kind_d;
    end
  end

endmodule

### rtl/core/ab2lp_outq.sv
// Result slots that hold the commands of one byte and release them one per transaction.
module ab2lp_outq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  ab2lp_pkg::result_set_t       results_i,
  input  logic [ab2lp_pkg::CNT_W-1:0]  count_i,
  output logic                         room_o,
  output logic                         valid_o,
  input  logic                         ready_i,
  output ab2lp_pkg::result_t           head_o
);

  ab2lp_pkg::result_set_t       slots_q, slots_d;
  logic [ab2lp_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic                         pop;

  always_comb begin
    valid_o = (cnt_q != '0);
    head_o  = slots_q[0];
    pop     = valid_o && ready_i;
    room_o  = (cnt_q == '0) || ((cnt_q == ab2lp_pkg::CNT_W'(1)) && ready_i);
    slots_d = slots_q;
    cnt_d   = cnt_q;
    if (push_i) begin
      slots_d = results_i;
      cnt_d   = count_i;
    end else if (pop) begin
      slots_d[0] = slots_q[1];
      slots_d[1] = slots_q[2];
      cnt_d      = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slots_q <= slots_d;
  end

endmodule
